FILE: hdl/cia_pkg.sv
package cia_pkg;

   localparam int WordBits = 64;
   localparam int ModeBits = 4;
   localparam int StatusBits = 2;

   localparam logic [ModeBits-1:0] OP_ADD = 4'd0;
   localparam logic [ModeBits-1:0] OP_SUB = 4'd1;
   localparam logic [ModeBits-1:0] OP_MUL = 4'd2;
   localparam logic [ModeBits-1:0] OP_NEG = 4'd3;
   localparam logic [ModeBits-1:0] OP_DIV = 4'd4;
   localparam logic [ModeBits-1:0] OP_MOD = 4'd5;
   localparam logic [ModeBits-1:0] OP_ABS = 4'd6;
   localparam logic [ModeBits-1:0] OP_MIN = 4'd7;
   localparam logic [ModeBits-1:0] OP_MAX = 4'd8;
   localparam logic [ModeBits-1:0] OP_LT  = 4'd9;
   localparam logic [ModeBits-1:0] OP_LE  = 4'd10;
   localparam logic [ModeBits-1:0] OP_GT  = 4'd11;
   localparam logic [ModeBits-1:0] OP_GE  = 4'd12;
   localparam logic [ModeBits-1:0] OP_EQ  = 4'd13;

   localparam logic [StatusBits-1:0] ST_OK   = 2'd0;
   localparam logic [StatusBits-1:0] ST_OVF  = 2'd1;
   localparam logic [StatusBits-1:0] ST_DIV0 = 2'd2;

   // classes the front end assigns
   localparam logic [1:0] CLS_SIMPLE = 2'd0;
   localparam logic [1:0] CLS_MUL    = 2'd1;
   localparam logic [1:0] CLS_DIV    = 2'd2;

endpackage

FILE: hdl/cia_if.sv
interface cia_req_if;
   import cia_pkg::*;
   logic valid;
   logic ready;
   logic [ModeBits-1:0] mode;
   logic signed [63:0] operand_a;
   logic signed [63:0] operand_b;
   modport source (output valid, mode, operand_a, operand_b, input ready);
   modport sink (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface cia_rsp_if;
   import cia_pkg::*;
   logic valid;
   logic ready;
   logic signed [63:0] value;
   logic [StatusBits-1:0] status;
   modport source (output valid, value, status, input ready);
   modport sink (input valid, value, status, output ready);
endinterface

FILE: hdl/cia_front.sv
// Front end: sign-extends operands and finishes every operation that needs
// no multiply or divide. Each entry carries a class tag for the back end.
module cia_front
   import cia_pkg::*;
#(
   parameter int WORD_BITS = WordBits
) (
   input  logic                  clock,
   input  logic                  reset,
   cia_req_if.sink               req,
   output logic                  ent_valid,
   input  logic                  ent_ready,
   output logic [1:0]            ent_cls,
   output logic [ModeBits-1:0]   ent_mode,
   output logic                  ent_na,
   output logic                  ent_nb,
   output logic [WORD_BITS-1:0]  ent_ma,
   output logic [WORD_BITS-1:0]  ent_mb,
   output logic [WORD_BITS-1:0]  ent_val,
   output logic [StatusBits-1:0] ent_st
);
   logic signed [WORD_BITS-1:0] a, b;
   logic signed [WORD_BITS:0] sum, dif;
   logic lt_ab, lt_ba, na, nb;
   logic [WORD_BITS-1:0] ma, mb, v;
   logic [StatusBits-1:0] st;
   logic [1:0] cls;
   logic [WORD_BITS-1:0] most_neg;

   assign a = req.operand_a[WORD_BITS-1:0];
   assign b = req.operand_b[WORD_BITS-1:0];
   assign na = a[WORD_BITS-1];
   assign nb = b[WORD_BITS-1];
   assign ma = na ? -a : a;
   assign mb = nb ? -b : b;
   assign most_neg = {1'b1, {(WORD_BITS-1){1'b0}}};
   assign sum = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
   assign dif = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
   assign lt_ab = a < b;
   assign lt_ba = b < a;

   always_comb begin
      v = '0;
      st = ST_OK;
      cls = CLS_SIMPLE;
      case (req.mode)
         OP_ADD: begin
            v = sum[WORD_BITS-1:0];
            if (sum[WORD_BITS] != sum[WORD_BITS-1]) st = ST_OVF;
         end
         OP_SUB: begin
            v = dif[WORD_BITS-1:0];
            if (dif[WORD_BITS] != dif[WORD_BITS-1]) st = ST_OVF;
         end
         OP_MUL: cls = CLS_MUL;
         OP_NEG, OP_ABS: begin
            if (a == most_neg) st = ST_OVF;
            else v = (req.mode == OP_NEG) ? -a : ma;
         end
         OP_DIV, OP_MOD: begin
            if (b == '0) st = ST_DIV0;
            else cls = CLS_DIV;
         end
         OP_MIN: v = lt_ba ? b : a;
         OP_MAX: v = lt_ab ? b : a;
         OP_LT: v = WORD_BITS'(lt_ab);
         OP_LE: v = WORD_BITS'(!lt_ba);
         OP_GT: v = WORD_BITS'(lt_ba);
         OP_GE: v = WORD_BITS'(!lt_ab);
         OP_EQ: v = WORD_BITS'(a == b);
         default: v = '0;
      endcase
      if (st != ST_OK) v = '0;
   end

   // single output register with skid-free flow: accept when empty or draining
   logic valid_ff;
   logic [1:0] cls_ff;
   logic [ModeBits-1:0] mode_ff;
   logic na_ff, nb_ff;
   logic [WORD_BITS-1:0] ma_ff, mb_ff, val_ff;
   logic [StatusBits-1:0] st_ff;

   assign req.ready = !valid_ff || ent_ready;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (req.ready) valid_ff <= req.valid;
      if (req.ready && req.valid) begin
         cls_ff <= cls; mode_ff <= req.mode; na_ff <= na; nb_ff <= nb;
         ma_ff <= ma; mb_ff <= mb; val_ff <= v; st_ff <= st;
      end
   end

   assign ent_valid = valid_ff;
   assign ent_cls = cls_ff;
   assign ent_mode = mode_ff;
   assign ent_na = na_ff;
   assign ent_nb = nb_ff;
   assign ent_ma = ma_ff;
   assign ent_mb = mb_ff;
   assign ent_val = val_ff;
   assign ent_st = st_ff;
endmodule

FILE: hdl/cia_back.sv
// Back end: pipelined unsigned multiplier (4 partial products, then sum)
// and a pipelined restoring divider, one quotient bit per stage. All items
// take the same path length so order is kept; a stall freezes the pipe.
module cia_back
   import cia_pkg::*;
#(
   parameter int WORD_BITS = WordBits
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ent_valid,
   output logic                  ent_ready,
   input  logic [1:0]            ent_cls,
   input  logic [ModeBits-1:0]   ent_mode,
   input  logic                  ent_na,
   input  logic                  ent_nb,
   input  logic [WORD_BITS-1:0]  ent_ma,
   input  logic [WORD_BITS-1:0]  ent_mb,
   input  logic [WORD_BITS-1:0]  ent_val,
   input  logic [StatusBits-1:0] ent_st,
   cia_rsp_if.source             rsp
);
   localparam int W = WORD_BITS;
   localparam int H = (W + 1) / 2;
   localparam int NS = W + 2;   // divider stages + sign fixup + pack

   logic adv;
   logic [NS-1:0] vld_ff;
   logic [1:0] cls_ff [NS];
   logic mode_div_ff [NS];
   logic na_ff [NS];
   logic nb_ff [NS];
   logic [W-1:0] mb_ff [NS];
   logic [W-1:0] q_ff [NS];    // dividend shifting into quotient
   logic [W-1:0] r_ff [NS];    // partial remainder
   logic [W-1:0] val_ff [NS];
   logic [StatusBits-1:0] st_ff [NS];
   logic [2*H-1:0] p00_ff, p01_ff, p10_ff, p11_ff;

   // output stage
   logic out_valid_ff;
   logic [W-1:0] out_val_ff;
   logic [StatusBits-1:0] out_st_ff;

   assign adv = !out_valid_ff || rsp.ready;
   assign ent_ready = adv;

   logic [W:0] trial [NS];
   always_comb begin
      for (int s = 0; s < NS; s++) trial[s] = '0;
      for (int s = 1; s <= W; s++)
         trial[s] = {r_ff[s-1], q_ff[s-1][W-1]} - {1'b0, mb_ff[s-1]};
   end

   // multiply partials
   logic [2*H-1:0] am, bm;
   assign am = (2*H)'(ent_ma);
   assign bm = (2*H)'(ent_mb);

   // multiply sum (stage 1), registered into val of stage 1 from the partial-product regs
   logic [4*H-1:0] prod;
   assign prod = (4*H)'(p00_ff) + ((4*H)'(p01_ff) << H) + ((4*H)'(p10_ff) << H)
                + ((4*H)'(p11_ff) << (2*H));
   logic mul_neg, mul_ok;
   logic [W-1:0] mul_v;
   always_comb begin
      mul_neg = na_ff[0] != nb_ff[0];
      mul_ok = (prod >> (W-1)) == '0 ||
               (mul_neg && prod == ((4*H)'(1) << (W-1)));
      mul_v = mul_ok ? (mul_neg ? -prod[W-1:0] : prod[W-1:0]) : '0;
   end

   // Euclidean fixup at last divider stage output (stage W)
   logic [W-1:0] fq, fr, dv;
   logic [StatusBits-1:0] dst;
   logic dneg;
   always_comb begin
      fq = q_ff[W];
      fr = r_ff[W];
      if (na_ff[W] && fr != '0) begin
         fq = fq + 1'b1;
         fr = mb_ff[W] - fr;
      end
      dneg = (na_ff[W] != nb_ff[W]) && fq != '0;
      dst = ST_OK;
      dv = '0;
      if (!mode_div_ff[W]) dv = fr;
      else if (dneg) begin
         if (fq > {1'b1, {(W-1){1'b0}}}) dst = ST_OVF;
         else dv = -fq;
      end else begin
         if (fq[W-1]) dst = ST_OVF;
         else dv = fq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], ent_valid};
         out_valid_ff <= vld_ff[NS-1];
      end
      if (adv) begin
         cls_ff[0] <= ent_cls; mode_div_ff[0] <= ent_mode == OP_DIV;
         na_ff[0] <= ent_na; nb_ff[0] <= ent_nb; mb_ff[0] <= ent_mb;
         q_ff[0] <= ent_ma; r_ff[0] <= '0;
         val_ff[0] <= ent_val; st_ff[0] <= ent_st;
         p00_ff <= (2*H)'(am[H-1:0] * bm[H-1:0]);
         p01_ff <= (2*H)'(am[H-1:0] * bm[2*H-1:H]);
         p10_ff <= (2*H)'(am[2*H-1:H] * bm[H-1:0]);
         p11_ff <= (2*H)'(am[2*H-1:H] * bm[2*H-1:H]);
         for (int s = 1; s < NS; s++) begin
            cls_ff[s] <= cls_ff[s-1]; mode_div_ff[s] <= mode_div_ff[s-1];
            na_ff[s] <= na_ff[s-1]; nb_ff[s] <= nb_ff[s-1];
            mb_ff[s] <= mb_ff[s-1];
            // product lands in stage 1, quotient/remainder in the last stage
            if (s == 1 && cls_ff[0] == CLS_MUL) begin
               val_ff[s] <= mul_v;
               st_ff[s] <= mul_ok ? ST_OK : ST_OVF;
            end else if (s == W + 1 && cls_ff[W] == CLS_DIV) begin
               val_ff[s] <= dv;
               st_ff[s] <= dst;
            end else begin
               val_ff[s] <= val_ff[s-1];
               st_ff[s] <= st_ff[s-1];
            end
            if (s <= W) begin
               if (!trial[s][W]) begin
                  r_ff[s] <= trial[s][W-1:0];
                  q_ff[s] <= {q_ff[s-1][W-2:0], 1'b1};
               end else begin
                  r_ff[s] <= {r_ff[s-1][W-2:0], q_ff[s-1][W-1]};
                  q_ff[s] <= {q_ff[s-1][W-2:0], 1'b0};
               end
            end else begin
               q_ff[s] <= q_ff[s-1];
               r_ff[s] <= r_ff[s-1];
            end
         end
         out_val_ff <= val_ff[NS-1];
         out_st_ff <= st_ff[NS-1];
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.value = 64'($signed(out_val_ff));
   assign rsp.status = out_st_ff;

   ast_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != ST_OK |-> rsp.value == '0)
      else $error("nonzero value with error status");
   ast_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.value))
      else $error("output changed under stall");
   ast_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.status == ST_OK || rsp.status == ST_OVF ||
                    rsp.status == ST_DIV0)
      else $error("bad status code");
endmodule

FILE: hdl/checked_integer_alu_core.sv
// Overflow-checked signed integer ALU.
// Channels: req (mode, operand_a, operand_b) and rsp (value, status), each a
// valid/ready interface; a transaction moves when valid and ready are high.
// Only the low WORD_BITS bits of each operand are used, taken as signed; the
// result is sign-extended to 64 bits and is zero whenever status is not ok.
// Throughput: one transaction per cycle for every opcode, back to back, while rsp
// is not stalled. The path from req acceptance to rsp valid has the same depth
// for all opcodes. The front register classifies and finishes simple ops; the
// back pipeline holds a 4-way split multiplier and a radix-2 divider with
// one quotient bit per stage, which sets the depth.
// Division and modulo are Euclidean: remainder in [0, |b|).
// Reset clears all valid bits; the data registers are not reset.
// When rsp is stalled the whole pipeline freezes and req.ready drops only
// once the front register is also full.
module checked_integer_alu_core
   import cia_pkg::*;
#(
   parameter int WORD_BITS = WordBits
) (
   input logic      clock,
   input logic      reset,
   cia_req_if.sink  req,
   cia_rsp_if.source rsp
);
   logic ent_valid, ent_ready, ent_na, ent_nb;
   logic [1:0] ent_cls;
   logic [ModeBits-1:0] ent_mode;
   logic [WORD_BITS-1:0] ent_ma, ent_mb, ent_val;
   logic [StatusBits-1:0] ent_st;

   cia_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock, .reset, .req,
      .ent_valid, .ent_ready, .ent_cls, .ent_mode, .ent_na, .ent_nb,
      .ent_ma, .ent_mb, .ent_val, .ent_st
   );

   cia_back #(.WORD_BITS(WORD_BITS)) u_back (
      .clock, .reset,
      .ent_valid, .ent_ready, .ent_cls, .ent_mode, .ent_na, .ent_nb,
      .ent_ma, .ent_mb, .ent_val, .ent_st, .rsp
   );
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import cia_pkg::*;

   // Expected result of one request transaction.
   typedef struct {
      logic signed [63:0] value;
      logic [StatusBits-1:0] status;
   } alu_result_type;

   // Signed limits of a 64-bit word.
   localparam logic [63:0] MostNeg = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MostPos = 64'h7fff_ffff_ffff_ffff;
   localparam int StallLimit = 4000;
   localparam int DrainCycles = WordBits + 20;
   localparam int RandomItems = 950;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int errors = 0;
   int idle_cycles = 0;
   bit stimulus_done = 1'b0;

   always #5 clock = ~clock;

   cia_req_if req ();
   cia_rsp_if rsp ();

   checked_integer_alu_core dut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   // One line per mismatch, and a running count.
   task automatic report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
   endtask

   // Random gap length: no gap more often than not, sometimes a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(2, 1);
      return $urandom_range(40, 5);
   endfunction

   // ------------------------------------------------------------------
   // Predictor of the ALU, 64-bit word.
   // ------------------------------------------------------------------
   // Range check of a sign and magnitude; zero value on overflow.
   function automatic alu_result_type pack_signed(input bit neg, input logic [63:0] mag);
      alu_result_type r;
      r.value = '0;
      r.status = ST_OK;
      if (neg) begin
         if (mag > MostNeg) r.status = ST_OVF;
         else r.value = -mag;
      end else begin
         if (mag > MostPos) r.status = ST_OVF;
         else r.value = mag;
      end
      return r;
   endfunction

   function automatic alu_result_type alu_predict(input logic [ModeBits-1:0] mode,
                                                  input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      alu_result_type r;
      logic [63:0] mag_a, mag_b, quot, rem;
      logic [127:0] prod;
      logic signed [64:0] wide;
      bit neg_a, neg_b;
      neg_a = a[63];
      neg_b = b[63];
      mag_a = neg_a ? -a : a;
      mag_b = neg_b ? -b : b;
      r.value = '0;
      r.status = ST_OK;
      case (mode)
         OP_ADD, OP_SUB: begin
            // exact sum in 65 bits, overflow when it leaves the word
            wide = (mode == OP_ADD) ? ({a[63], a} + {b[63], b}) : ({a[63], a} - {b[63], b});
            if (wide[64] != wide[63]) r.status = ST_OVF;
            else r.value = wide[63:0];
         end
         OP_MUL: begin
            prod = {64'd0, mag_a} * {64'd0, mag_b};
            if (prod[127:64] != 0) r.status = ST_OVF;
            else r = pack_signed(neg_a != neg_b, prod[63:0]);
         end
         OP_NEG: r = pack_signed(!neg_a, mag_a);
         OP_ABS: r = pack_signed(1'b0, mag_a);
         OP_DIV, OP_MOD: begin
            if (mag_b == 0) begin
               r.status = ST_DIV0;
            end else begin
               quot = mag_a / mag_b;
               rem = mag_a % mag_b;
               // Euclidean: negative dividend rounds away so remainder stays >= 0
               if (neg_a && rem != 0) begin
                  quot = quot + 1;
                  rem = mag_b - rem;
               end
               if (mode == OP_DIV) r = pack_signed(neg_a != neg_b && quot != 0, quot);
               else r = pack_signed(1'b0, rem);
            end
         end
         OP_MIN: r.value = (b < a) ? b : a;
         OP_MAX: r.value = (a < b) ? b : a;
         OP_LT: r.value = (a < b) ? 64'sd1 : 64'sd0;
         OP_LE: r.value = (a <= b) ? 64'sd1 : 64'sd0;
         OP_GT: r.value = (a > b) ? 64'sd1 : 64'sd0;
         OP_GE: r.value = (a >= b) ? 64'sd1 : 64'sd0;
         OP_EQ: r.value = (a == b) ? 64'sd1 : 64'sd0;
         default: r.value = '0;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Scoreboard: queue of expected results in transaction order.
   // ------------------------------------------------------------------
   class alu_scoreboard;
      alu_result_type pending[$];

      function void note_request(input logic [ModeBits-1:0] mode,
                                 input logic signed [63:0] a,
                                 input logic signed [63:0] b);
         pending.push_back(alu_predict(mode, a, b));
      endfunction

      task check_result(input logic signed [63:0] value,
                        input logic [StatusBits-1:0] status);
         alu_result_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result value=%0d status=%0d", value, status));
            return;
         end
         want = pending.pop_front();
         if (value !== want.value)
            report($sformatf("value %0d, expected %0d", value, want.value));
         if (status !== want.status)
            report($sformatf("status %0d, expected %0d", status, want.status));
      endtask
   endclass

   alu_scoreboard results = new();

   // Directed requests, filled before the random part.
   logic [ModeBits-1:0] dir_mode[$];
   logic signed [63:0] dir_a[$], dir_b[$];

   task automatic add_directed(input logic [ModeBits-1:0] mode,
                               input logic [63:0] a, input logic [63:0] b);
      dir_mode.push_back(mode);
      dir_a.push_back(a);
      dir_b.push_back(b);
   endtask

   function automatic logic [63:0] pick_operand();
      int roll;
      roll = $urandom_range(9);
      case (roll)
         0: return MostNeg;
         1: return MostPos;
         2: return 64'(signed'($urandom_range(8)) - 4);
         3: return {{32{$urandom_range(1) == 1}}, $urandom()};
         4: return {$urandom(), 32'(0)} >> $urandom_range(63);
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // Drive one request and hold it until accepted; valid stays high into
   // the next request when there is no gap.
   task automatic send_request(input logic [ModeBits-1:0] mode,
                               input logic [63:0] a, input logic [63:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.mode <= mode;
      req.operand_a <= a;
      req.operand_b <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      results.note_request(mode, a, b);
   endtask

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   initial begin
      logic [ModeBits-1:0] mode;
      logic [63:0] a, b;
      req.valid = 1'b0;
      req.mode = '0;
      req.operand_a = '0;
      req.operand_b = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // extremes, every opcode, and the special cases
      add_directed(OP_ADD, MostPos, 64'd1);
      add_directed(OP_ADD, MostNeg, MostNeg);
      add_directed(OP_SUB, MostNeg, 64'd1);
      add_directed(OP_SUB, 64'd0, MostNeg);
      add_directed(OP_MUL, MostNeg, 64'd1);
      add_directed(OP_MUL, 64'h4000_0000_0000_0000, -64'sd2);
      add_directed(OP_MUL, 64'h4000_0000_0000_0000, 64'd2);
      add_directed(OP_MUL, MostPos, MostPos);
      add_directed(OP_NEG, MostNeg, MostPos);
      add_directed(OP_NEG, MostPos, 64'd0);
      add_directed(OP_DIV, 64'd7, 64'd0);
      add_directed(OP_MOD, MostNeg, 64'd0);
      add_directed(OP_DIV, MostNeg, -64'sd1);
      add_directed(OP_MOD, MostNeg, -64'sd1);
      add_directed(OP_DIV, -64'sd7, 64'd2);
      add_directed(OP_MOD, -64'sd7, -64'sd2);
      add_directed(OP_ABS, MostNeg, 64'd5);
      add_directed(OP_ABS, -64'sd3, MostNeg);
      add_directed(OP_MIN, MostNeg, MostPos);
      add_directed(OP_MAX, MostNeg, MostPos);
      add_directed(OP_LT, MostNeg, MostPos);
      add_directed(OP_LE, 64'd5, 64'd5);
      add_directed(OP_GT, MostPos, MostNeg);
      add_directed(OP_GE, -64'sd1, 64'd0);
      add_directed(OP_EQ, -64'sd1, -64'sd1);
      add_directed(4'd14, 64'd1, 64'd2);
      add_directed(4'd15, MostNeg, MostPos);
      foreach (dir_mode[i]) send_request(dir_mode[i], dir_a[i], dir_b[i]);

      for (int n = 0; n < RandomItems; n++) begin
         mode = $urandom_range(15);
         a = pick_operand();
         b = pick_operand();
         send_request(mode, a, b);
      end
      req.valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // ------------------------------------------------------------------
   // Result side: random backpressure, check on each transaction
   // ------------------------------------------------------------------
   initial begin
      int gap;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         gap = pick_gap();
         if (gap == 0) begin
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp.ready <= 1'b1;
         end
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         results.check_result(rsp.value, rsp.status);
      end
   end

   // Watchdog: cycles without any transaction.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("watchdog: no transaction for %0d cycles", StallLimit);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // End of run: drain, then wait out DrainCycles for stray results.
   initial begin
      wait (stimulus_done);
      while (results.pending.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/cia_pkg.sv
hdl/cia_if.sv
hdl/cia_front.sv
hdl/cia_back.sv
hdl/checked_integer_alu_core.sv
tb/testbench.sv
